>>> hw/rtl/elpr_pkg.sv
// ----------------------------------------------------------------------------
// elpr_pkg
// shared widths and register indexes for the pattern replace block
// ----------------------------------------------------------------------------
package elpr_pkg;

	localparam int BYTE_W     = 8;
	localparam int PAT_W      = 128;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int LEN_W      = 5;
	localparam int SKIP_W     = 4;
	localparam int HITS_W     = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OLD_LO  = 3'd0,
		CFG_OLD_HI  = 3'd1,
		CFG_NEW_LO  = 3'd2,
		CFG_NEW_HI  = 3'd3,
		CFG_PAT_LEN = 3'd4
	} cfg_idx_t;

endpackage

>>> hw/rtl/elpr_window.sv
// ----------------------------------------------------------------------------
// elpr_window
// delay window with masked pattern compare, replacement and hit counting
// ----------------------------------------------------------------------------
module elpr_window import elpr_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
	localparam int CW = $clog2(MAX_PATTERN + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [BYTE_W-1:0]                   in_byte,
	input  logic                                in_last,
	input  logic [PAT_W-1:0]                    old_pat,
	input  logic [PAT_W-1:0]                    new_pat,
	input  logic [LEN_W-1:0]                    pat_len,
	output logic [MAX_PATTERN-1:0][BYTE_W-1:0]  res_byte,
	output logic [MAX_PATTERN-1:0]              res_rep,
	output logic [IW-1:0]                       res_start,
	output logic [CW-1:0]                       res_count,
	output logic [HITS_W-1:0]                   res_hits
);

	localparam int SW = CW + 1;

	// window is kept right aligned: newest byte at the top entry
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] wbyte_q;
	logic [MAX_PATTERN-1:0]             wrep_q;
	logic [IW-1:0]                      fill_q;
	logic [SKIP_W-1:0]                  skip_q;
	logic [HITS_W-1:0]                  hits_q;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] a_byte;
	logic [MAX_PATTERN-1:0]             a_rep;
	logic [MAX_PATTERN-1:0]             in_win;
	logic [MAX_PATTERN-1:0][3:0]        pat_idx;
	logic [CW-1:0]                      n;
	logic [CW-1:0]                      len;
	logic [CW-1:0]                      keep;
	logic [SW-1:0]                      pos_sum;
	logic                               full;
	logic                               eq_all;
	logic                               hit;

	always_comb begin
		n = CW'(fill_q) + CW'(1);
		if (pat_len == '0) begin
			len = CW'(1);
		end else if (pat_len > LEN_W'(MAX_PATTERN)) begin
			len = CW'(MAX_PATTERN);
		end else begin
			len = CW'(pat_len);
		end
		full = (n >= len);

		a_byte[MAX_PATTERN-1] = in_byte;
		a_rep[MAX_PATTERN-1]  = 1'b0;
		for (int p = 0; p < MAX_PATTERN - 1; p++) begin
			a_byte[p] = wbyte_q[p+1];
			a_rep[p]  = wrep_q[p+1];
		end

		// pattern byte j lines up with window entry MAX_PATTERN-len+j
		eq_all = 1'b1;
		for (int p = 0; p < MAX_PATTERN; p++) begin
			pos_sum    = SW'(p) + SW'(len);
			in_win[p]  = (pos_sum >= SW'(MAX_PATTERN));
			pat_idx[p] = 4'(pos_sum - SW'(MAX_PATTERN));
			if (in_win[p] && a_byte[p] != old_pat[{pat_idx[p], 3'b000} +: BYTE_W]) begin
				eq_all = 1'b0;
			end
		end
		hit = full && (skip_q == '0) && eq_all;

		for (int p = 0; p < MAX_PATTERN; p++) begin
			if (hit && in_win[p]) begin
				res_byte[p] = new_pat[{pat_idx[p], 3'b000} +: BYTE_W];
				res_rep[p]  = 1'b1;
			end else begin
				res_byte[p] = a_byte[p];
				res_rep[p]  = a_rep[p];
			end
		end

		if (hit && hits_q != '1) begin
			res_hits = hits_q + HITS_W'(1);
		end else begin
			res_hits = hits_q;
		end

		keep      = full ? (len - CW'(1)) : n;
		res_count = in_last ? n : (n - keep);
		res_start = IW'(SW'(MAX_PATTERN) - SW'(n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			skip_q <= '0;
			hits_q <= '0;
		end else if (step) begin
			if (in_last) begin
				fill_q <= '0;
				skip_q <= '0;
				hits_q <= '0;
			end else begin
				fill_q <= IW'(keep);
				hits_q <= res_hits;
				if (full) begin
					if (skip_q != '0) begin
						skip_q <= skip_q - SKIP_W'(1);
					end else if (hit) begin
						skip_q <= SKIP_W'(len - CW'(1));
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !in_last) begin
			wbyte_q <= res_byte;
			wrep_q  <= res_rep;
		end
	end

endmodule

>>> hw/rtl/equal_length_pattern_replace.sv
// ----------------------------------------------------------------------------
// equal_length_pattern_replace
// byte stream find and replace of an equal length pattern, greedy, no overlap
//
//  channel   dir  fields (low bit up)                     transaction when
//  s_*       in   tdata: in_byte; tlast: in_last          s_tvalid & s_tready
//  m_*       out  tdata: out_byte, stream_hits;           m_tvalid & m_tready
//                 tuser: out_replaced; tlast: out_last
//  cfg_*     in   cfg_idx, cfg_data                       cfg_we
//
//  one byte per cycle unless m_* stalls or a flush or shortened length drains; a byte leaves
//  pattern_len-1 bytes later, valid the cycle after its releasing transaction
//  a stream's last byte flushes the window: n results (up to MAX_PATTERN)
//  drain one per ready cycle; the next byte enters as the final one leaves
//  a shortened pattern_len mid-stream likewise drains the excess bytes
//  reset empties the window and result buffer, clears counters, loads config
// ----------------------------------------------------------------------------
module equal_length_pattern_replace import elpr_pkg::*; #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // in_byte
	input  logic                  s_tlast,   // in_last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // out_byte, stream_hits
	output logic                  m_tuser,   // out_replaced
	output logic                  m_tlast    // out_last
);

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = $clog2(MAX_PATTERN + 1);

	logic [CFG_DATA_W-1:0] old_lo_q, old_hi_q, new_lo_q, new_hi_q;
	logic [LEN_W-1:0]      pat_len_q;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] res_byte;
	logic [MAX_PATTERN-1:0]             res_rep;
	logic [IW-1:0]                      res_start;
	logic [CW-1:0]                      res_count;
	logic [HITS_W-1:0]                  res_hits;

	// result buffer, read from rd_q onward
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] ebyte_q;
	logic [MAX_PATTERN-1:0]             erep_q;
	logic [HITS_W-1:0]                  ehits_q;
	logic [IW-1:0]                      rd_q;
	logic [CW-1:0]                      rem_q;
	logic                               elast_q;

	logic s_fire;
	logic m_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_lo_q  <= '0;
			old_hi_q  <= '0;
			new_lo_q  <= '0;
			new_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_OLD_LO:  old_lo_q  <= cfg_data;
				CFG_OLD_HI:  old_hi_q  <= cfg_data;
				CFG_NEW_LO:  new_lo_q  <= cfg_data;
				CFG_NEW_HI:  new_hi_q  <= cfg_data;
				CFG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	elpr_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s_fire),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.old_pat   ({old_hi_q, old_lo_q}),
		.new_pat   ({new_hi_q, new_lo_q}),
		.pat_len   (pat_len_q),
		.res_byte  (res_byte),
		.res_rep   (res_rep),
		.res_start (res_start),
		.res_count (res_count),
		.res_hits  (res_hits)
	);

	assign m_tvalid = (rem_q != '0);
	assign m_fire   = m_tvalid && m_tready;
	// next byte may enter as the final buffered result leaves
	assign s_tready = (rem_q == '0) || (rem_q == CW'(1) && m_tready);
	assign s_fire   = s_tvalid && s_tready;

	assign m_tdata = {ehits_q, ebyte_q[rd_q]};
	assign m_tuser = erep_q[rd_q];
	assign m_tlast = elast_q && (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			rem_q   <= '0;
			elast_q <= 1'b0;
		end else if (s_fire) begin
			rd_q    <= res_start;
			rem_q   <= res_count;
			elast_q <= s_tlast;
		end else if (m_fire) begin
			rd_q  <= rd_q + IW'(1);
			rem_q <= rem_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			ebyte_q <= res_byte;
			erep_q  <= res_rep;
			ehits_q <= res_hits;
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// pattern replace block driven with byte streams: a scripted part covering
// pattern length extremes, out-of-range lengths, short streams and a length
// change mid-stream, then random phases of streams rich in pattern runs;
// every output transaction is checked against a scripted value or an in-bench model of the
// window, the overlap skip and the hit count
// ----------------------------------------------------------------------------
module tb;
	import elpr_pkg::*;

	localparam int N_RANDOM   = 300;
	localparam int SETTLE     = 24;
	localparam int CYCLE_CAP  = 600000;
	localparam int CALM_ITEMS = 50;

	typedef struct {
		logic [7:0]  b;
		bit          rep;
		bit          last;
		logic [31:0] hits;
	} out_item_t;

	typedef struct {
		bit          is_cfg;
		cfg_idx_t    idx;
		logic [63:0] value;
		logic [7:0]  data;
		bit          last;
		bit          typed;
		out_item_t   want;
	} row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;   // in_byte
	logic                  s_tlast  = 1'b0; // in_last
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;         // out_byte, stream_hits
	logic                  m_tuser;         // out_replaced
	logic                  m_tlast;         // out_last

	equal_length_pattern_replace uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// shadow configuration
	logic [127:0] old_pat = '0;
	logic [127:0] new_pat = '0;
	logic [4:0]   len_reg = 5'd1;

	// shadow stream state
	logic [7:0]  win_b [16];
	bit          win_r [16];
	int          win_fill  = 0;
	int          skip_left = 0;
	logic [31:0] hit_cnt   = '0;

	out_item_t due_bytes [$];
	out_item_t no_want;
	out_item_t head;
	row_t      script [$];

	int  errors     = 0;
	int  checked    = 0;
	int  sent       = 0;
	int  streams    = 0;
	int  phases     = 0;
	int  cycles     = 0;
	int  ready_left = 0;
	bit  calm       = 1'b0;
	bit  stream_open = 1'b0;

	function automatic int eff_len();
		int l;
		l = len_reg;
		if (l < 1) l = 1;
		if (l > 16) l = 16;
		return l;
	endfunction

	function automatic logic [7:0] pat_at(logic [127:0] p, int j);
		return p[8*(j & 15) +: 8];
	endfunction

	task automatic predict_replace(input logic [7:0] b, input bit is_last);
		logic [7:0] cb [16];
		bit         cr [16];
		int         l, n, base, k, i;
		bit         eq;
		out_item_t  o;
		l = eff_len();
		for (i = 0; i < win_fill; i++) begin
			cb[i] = win_b[i];
			cr[i] = win_r[i];
		end
		cb[win_fill] = b;
		cr[win_fill] = 1'b0;
		n = win_fill + 1;
		if (n >= l) begin
			base = n - l;
			if (skip_left > 0) begin
				skip_left--;
			end else begin
				eq = 1'b1;
				for (i = 0; i < l; i++)
					if (cb[base+i] != pat_at(old_pat, i)) eq = 1'b0;
				if (eq) begin
					if (hit_cnt != 32'hFFFF_FFFF) hit_cnt++;
					for (i = 0; i < l; i++) begin
						cb[base+i] = pat_at(new_pat, i);
						cr[base+i] = 1'b1;
					end
					skip_left = (l - 1) & 15;
				end
			end
		end
		if (is_last) begin
			for (i = 0; i < n; i++) begin
				o.b = cb[i]; o.rep = cr[i]; o.last = (i == n - 1); o.hits = hit_cnt;
				due_bytes.push_back(o);
			end
			win_fill = 0;
			skip_left = 0;
			hit_cnt = '0;
			for (i = 0; i < 16; i++) win_r[i] = 1'b0;
		end else begin
			k = (n > l - 1) ? n - (l - 1) : 0;
			for (i = 0; i < k; i++) begin
				o.b = cb[i]; o.rep = cr[i]; o.last = 1'b0; o.hits = hit_cnt;
				due_bytes.push_back(o);
			end
			win_fill = n - k;
			for (i = 0; i < 16; i++) begin
				if (i < win_fill) begin
					win_b[i] = cb[k+i];
					win_r[i] = cr[k+i];
				end else begin
					win_r[i] = 1'b0;
				end
			end
		end
	endtask

	// holds the byte until a transaction, then predicts at that edge
	task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
			input out_item_t want);
		int qn;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		qn = due_bytes.size();
		predict_replace(b, is_last);
		if (typed) begin
			while (due_bytes.size() > qn) void'(due_bytes.pop_back());
			due_bytes.push_back(want);
		end
		sent++;
		if (is_last) streams++;
		stream_open = !is_last;
	endtask

	task automatic maybe_pause();
		int n;
		if (!calm && $urandom_range(3, 0) == 0) begin
			n = $urandom_range(14, 1);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sender holds off until every expected transaction has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_OLD_LO:  old_pat[63:0]   = v;
			CFG_OLD_HI:  old_pat[127:64] = v;
			CFG_NEW_LO:  new_pat[63:0]   = v;
			CFG_NEW_HI:  new_pat[127:64] = v;
			CFG_PAT_LEN: len_reg         = v[4:0];
			default: ;
		endcase
	endtask

	function automatic row_t cfg_row(cfg_idx_t idx, logic [63:0] v);
		row_t r;
		r = '{idx: CFG_OLD_LO, default: 0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.value = v;
		return r;
	endfunction

	function automatic row_t byte_row(logic [7:0] d, bit l);
		row_t r;
		r = '{idx: CFG_OLD_LO, default: 0};
		r.idx = CFG_OLD_LO;
		r.data = d;
		r.last = l;
		return r;
	endfunction

	function automatic row_t typed_row(logic [7:0] d, logic [7:0] eb, bit er, logic [31:0] eh);
		row_t r;
		r = byte_row(d, 1'b1);
		r.typed = 1'b1;
		r.want.b = eb;
		r.want.rep = er;
		r.want.last = 1'b1;
		r.want.hits = eh;
		return r;
	endfunction

	// receiver stalls in bursts
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (calm || $urandom_range(2, 0) != 0) begin
			m_tready   <= 1'b1;
			ready_left <= $urandom_range(30, 1);
		end else begin
			m_tready   <= 1'b0;
			ready_left <= $urandom_range(13, 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_bytes.size() == 0) begin
				$error("unexpected transaction: out_byte %0h", m_tdata[7:0]);
				errors++;
			end else begin
				head = due_bytes.pop_front();
				checked++;
				if (m_tdata[7:0] !== head.b) begin
					$error("out_byte: expected %0h, actual %0h", head.b, m_tdata[7:0]);
					errors++;
				end
				if (m_tuser !== head.rep) begin
					$error("out_replaced: expected %0d, actual %0d", head.rep, m_tuser);
					errors++;
				end
				if (m_tlast !== head.last) begin
					$error("out_last: expected %0d, actual %0d", head.last, m_tlast);
					errors++;
				end
				if (m_tdata[39:8] !== head.hits) begin
					$error("stream_hits: expected %0d, actual %0d", head.hits, m_tdata[39:8]);
					errors++;
				end
			end
		end
	end

	initial begin
		int          i, r, l, n_bytes, n_streams, s, j, pos;
		bit          prev_cfg, open_end, is_last;
		logic [7:0]  b, fillb;

		no_want = '{default: 0};
		for (i = 0; i < 16; i++) begin
			win_b[i] = '0;
			win_r[i] = 1'b0;
		end

		// after reset: length 1, both patterns zero
		script.push_back(typed_row(8'h00, 8'h00, 1'b1, 32'd1));
		script.push_back(typed_row(8'hFF, 8'hFF, 1'b0, 32'd0));
		// length zero behaves as one
		script.push_back(cfg_row(CFG_NEW_LO, 64'h5A));
		script.push_back(cfg_row(CFG_OLD_LO, 64'hA5));
		script.push_back(cfg_row(CFG_PAT_LEN, 64'd0));
		script.push_back(typed_row(8'hA5, 8'h5A, 1'b1, 32'd1));
		// full 16 byte match, length above the maximum clamps
		script.push_back(cfg_row(CFG_OLD_LO, 64'h0706_0504_0302_0100));
		script.push_back(cfg_row(CFG_OLD_HI, 64'h0F0E_0D0C_0B0A_0908));
		script.push_back(cfg_row(CFG_NEW_LO, '1));
		script.push_back(cfg_row(CFG_NEW_HI, '1));
		script.push_back(cfg_row(CFG_PAT_LEN, 64'd20));
		for (i = 0; i < 16; i++) script.push_back(byte_row(i[7:0], i == 15));
		// short stream, then length shortened while the window holds bytes
		script.push_back(cfg_row(CFG_PAT_LEN, 64'd4));
		script.push_back(byte_row(8'h10, 1'b0));
		script.push_back(byte_row(8'h00, 1'b0));
		script.push_back(byte_row(8'h01, 1'b0));
		script.push_back(cfg_row(CFG_PAT_LEN, 64'd2));
		script.push_back(byte_row(8'h00, 1'b0));
		script.push_back(byte_row(8'h01, 1'b1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		prev_cfg = 1'b0;
		foreach (script[k]) begin
			if (script[k].is_cfg) begin
				if (!prev_cfg) wait_idle();
				write_reg(script[k].idx, script[k].value);
			end else begin
				if (prev_cfg) cfg_we <= 1'b0;
				else maybe_pause();
				send_byte(script[k].data, script[k].last, script[k].typed, script[k].want);
			end
			prev_cfg = script[k].is_cfg;
		end
		if (prev_cfg) cfg_we <= 1'b0;

		// random phases: new settings, then streams built mostly from pattern runs
		while (sent < N_RANDOM + 24) begin
			wait_idle();
			phases++;
			r = $urandom_range(11, 0);
			if (r < 7) l = $urandom_range(4, 1);
			else if (r < 9) l = $urandom_range(16, 5);
			else if (r == 9) l = 16;
			else if (r == 10) l = 0;
			else l = $urandom_range(31, 17);
			write_reg(CFG_PAT_LEN, 64'(l));
			if (phases == 1 || $urandom_range(1, 0) != 0) begin
				fillb = 8'($urandom_range(255, 0));
				if ($urandom_range(2, 0) == 0) begin
					write_reg(CFG_OLD_LO, {8{fillb}});
					write_reg(CFG_OLD_HI, {8{fillb}});
				end else begin
					write_reg(CFG_OLD_LO, {$urandom, $urandom});
					write_reg(CFG_OLD_HI, {$urandom, $urandom});
				end
			end
			if ($urandom_range(1, 0) != 0) begin
				case ($urandom_range(2, 0))
					0: begin
						write_reg(CFG_NEW_LO, '0);
						write_reg(CFG_NEW_HI, '0);
					end
					1: begin
						write_reg(CFG_NEW_LO, '1);
						write_reg(CFG_NEW_HI, '1);
					end
					default: begin
						write_reg(CFG_NEW_LO, {$urandom, $urandom});
						write_reg(CFG_NEW_HI, {$urandom, $urandom});
					end
				endcase
			end
			cfg_we <= 1'b0;

			l = eff_len();
			n_streams = $urandom_range(3, 1);
			open_end = ($urandom_range(3, 0) == 0);
			for (s = 0; s < n_streams; s++) begin
				n_bytes = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20)
					: $urandom_range(12, 1);
				pos = 0;
				for (j = 0; j < n_bytes; j++) begin
					calm = (sent >= N_RANDOM + 24 - CALM_ITEMS);
					if ($urandom_range(3, 0) == 0) begin
						b = 8'($urandom_range(255, 0));
					end else begin
						b = pat_at(old_pat, pos);
						pos = (pos + 1) % l;
						if ($urandom_range(7, 0) == 0) pos = 0;
					end
					is_last = (j == n_bytes - 1) && !(open_end && s == n_streams - 1);
					maybe_pause();
					send_byte(b, is_last, 1'b0, no_want);
				end
			end
		end

		if (stream_open) send_byte(8'($urandom_range(255, 0)), 1'b1, 1'b0, no_want);
		s_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("summary: %0d bytes in %0d streams over %0d random phases",
			sent, streams, phases);
		$display("summary: %0d output transactions compared, %0d mismatches",
			checked, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
